>>> src/ntts_pkg.sv
// Shared types and constants of the nearest threshold tracking search unit.
package ntts_pkg;

  // Field widths of the stream items and of the registers.
  localparam int REF_W     = 24;
  localparam int TRK_W     = 16;
  localparam int THR_W     = 24;
  localparam int POS_W     = 28;
  localparam int IDX_OUT_W = 12;
  localparam int OFFSET_W  = 16;
  localparam int STEP_W    = 12;
  localparam int QCNT_W    = 16;
  localparam int DIST_W    = THR_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Packed stream widths.
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 144;
  localparam int M_TUSER_W = 1;

  localparam logic signed [REF_W-1:0] REF_MAX  = 24'sh7FFFFF;
  localparam logic signed [REF_W-1:0] REF_MIN  = 24'sh800000;
  localparam logic signed [TRK_W-1:0] TRK_MAX  = 16'sh7FFF;
  localparam logic [POS_W-1:0]        POS_MAX  = 28'hFFFFFFF;
  localparam logic [QCNT_W-1:0]       QCNT_MAX = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_STEP   = 1'b1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REF_ADDR,
    ST_REF_DATA,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic clear;
    logic sample_valid;
  } dist_ctrl_t;

  typedef struct packed {
    logic found;
    logic busy;
  } dist_stat_t;

endpackage

>>> src/ntts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ntts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ntts_dist_unit.sv
// Shared distance and compare unit that keeps the earliest closest sample.
module ntts_dist_unit #(
  parameter int IDX_W = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ntts_pkg::dist_ctrl_t              ctrl_i,
  input  logic signed [ntts_pkg::THR_W-1:0] threshold_i,
  input  logic signed [ntts_pkg::TRK_W-1:0] sample_i,
  input  logic [IDX_W-1:0]                  idx_i,
  output ntts_pkg::dist_stat_t              stat_o,
  output logic [IDX_W-1:0]                  target_o
);
  import ntts_pkg::*;

  logic signed [DIST_W-1:0] diff;
  logic [DIST_W-1:0]        abs_gap;
  logic                     v1_q;
  logic [DIST_W-1:0]        d_q;
  logic [IDX_W-1:0]         idx1_q;
  logic [DIST_W-1:0]        best_q;
  logic [IDX_W-1:0]         target_q;
  logic                     found_q;
  logic                     take;

  // The tracking sample is scaled to Q.8 before the difference is taken.
  assign diff = {threshold_i[THR_W-1], threshold_i}
              - {sample_i[TRK_W-1], sample_i, 8'h00};
  assign abs_gap = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

  // A strict compare keeps the earliest sample on a tie.
  assign take = v1_q && (!found_q || (d_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      found_q  <= 1'b0;
      target_q <= '0;
    end else if (ctrl_i.clear) begin
      v1_q     <= 1'b0;
      found_q  <= 1'b0;
      target_q <= '0;
    end else begin
      v1_q <= ctrl_i.sample_valid;
      if (take) begin
        found_q  <= 1'b1;
        target_q <= idx1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample_valid) begin
      d_q    <= abs_gap;
      idx1_q <= idx_i;
    end
    if (take) begin
      best_q <= d_q;
    end
  end

  assign stat_o.found = found_q;
  assign stat_o.busy  = v1_q;
  assign target_o     = target_q;

endmodule

>>> src/nearest_threshold_tracking_search_unit.sv
// Top level of the nearest threshold tracking search unit: sequencer, stores and result stage.
//
// The unit keeps a frame of paired reference and tracking samples and answers threshold
// queries against it. A load item (operation 0) does not make the unit busy and writes the
// pair at the next free index, while the first index of the smallest tracking sample is
// tracked; frame_start on a load clears the frame and all search state first, and loads
// beyond MAX_SAMPLES samples are dropped. A query item (operation 1) scans the tracking
// samples from the last matched index up to, but not including, the minimum index, and at
// most SEARCH_WINDOW samples, and picks the earliest sample whose Q.8 scaled value lies
// closest to the threshold. A query occupies the unit from its acceptance until its result
// is ready, also when its window is empty, and the input is not ready during that time: the
// tracking store has one read port, the shared distance unit takes one sample per cycle
// behind the store's registered read and its pipeline must then drain, and the reference
// store is read once at the chosen index before the result is formed. The
// result then sits in an output register, so the unit takes further loads and queries while
// it waits to be taken; a query that finishes while the previous result is still held waits
// until the output register is free. The stores need no clearing pass, since only entries
// below the sample count are ever read. Configuration writes are taken at any time, but are
// meant to happen only while the unit is idle.
module nearest_threshold_tracking_search_unit #(
  parameter int MAX_SAMPLES   = 4096,
  parameter int SEARCH_WINDOW = 1000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input item stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0 up: reference_sample[23:0], tracking_sample[39:24],
  // threshold_value[63:40].
  input  logic [ntts_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser from bit 0 up: operation[0], frame_start[1].
  input  logic [ntts_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  // Result item stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0 up: position[27:0], matched_reference[51:28], matched_index[63:52],
  // lowest_reference[87:64], highest_reference[111:88], highest_position[139:112],
  // zero fill[143:140].
  output logic [ntts_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // tuser from bit 0 up: empty_window[0].
  output logic [ntts_pkg::M_TUSER_W-1:0]     m_axis_tuser,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [ntts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ntts_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import ntts_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int EW = $clog2(MAX_SAMPLES + SEARCH_WINDOW + 1);

  // Unpacked input fields.
  logic                     in_op;
  logic                     in_fs;
  logic signed [REF_W-1:0]  in_ref;
  logic signed [TRK_W-1:0]  in_trk;
  logic signed [THR_W-1:0]  in_thr;

  assign in_op  = s_axis_tuser[0];
  assign in_fs  = s_axis_tuser[1];
  assign in_ref = s_axis_tdata[23:0];
  assign in_trk = s_axis_tdata[39:24];
  assign in_thr = s_axis_tdata[63:40];

  seq_state_e state_q, state_d;

  // Configuration registers.
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [STEP_W-1:0]   step_q, step_d;

  // Frame and search state.
  logic [CW-1:0]            count_q, count_d;
  logic [IW-1:0]            min_idx_q, min_idx_d;
  logic signed [TRK_W-1:0]  min_val_q, min_val_d;
  logic [IW-1:0]            ss_q, ss_d;
  logic [QCNT_W-1:0]        qcnt_q, qcnt_d;
  logic signed [REF_W-1:0]  low_q, low_d;
  logic signed [REF_W-1:0]  high_q, high_d;
  logic [POS_W-1:0]         phigh_q, phigh_d;

  // Working registers of one query.
  logic signed [THR_W-1:0]  thr_q;
  logic [CW-1:0]            end_q;
  logic [CW-1:0]            j_q;
  logic                     rv_q;
  logic [IW-1:0]            ridx_q;
  logic [POS_W-1:0]         prod_q;
  logic signed [REF_W-1:0]  mref_q;
  logic [POS_W-1:0]         pos_q;

  // Result register.
  logic                     m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]     m_data_q;
  logic [M_TUSER_W-1:0]     m_user_q;

  // Sequencer outputs.
  logic       in_fire;
  logic       load_fire;
  logic       query_fire;
  logic       scan_issue;
  logic       trk_re;
  logic       ref_re;
  logic       fin_fire;
  dist_ctrl_t dist_ctrl;
  dist_stat_t dist_stat;

  logic [IW-1:0] target;

  // Read data of the sample stores.
  logic signed [TRK_W-1:0] trk_rdata;
  logic signed [REF_W-1:0] ref_rdata;

  // Load path: the frame is cleared first when frame_start is set.
  logic [CW-1:0]           base_cnt;
  logic [IW-1:0]           base_min_idx;
  logic signed [TRK_W-1:0] base_min_val;
  logic                    has_room;
  logic                    load_store;

  assign base_cnt     = in_fs ? '0 : count_q;
  assign base_min_idx = in_fs ? '0 : min_idx_q;
  assign base_min_val = in_fs ? TRK_MAX : min_val_q;
  assign has_room     = base_cnt < CW'(MAX_SAMPLES);
  assign load_store   = load_fire && has_room;

  // Search end: the smallest of the window end, the minimum index and the sample count.
  logic [EW-1:0] win_end;
  logic [EW-1:0] end_a;
  logic [EW-1:0] end_b;

  assign win_end = EW'(ss_q) + EW'(SEARCH_WINDOW);
  assign end_a   = (EW'(min_idx_q) < win_end) ? EW'(min_idx_q) : win_end;
  assign end_b   = (EW'(count_q) < end_a) ? EW'(count_q) : end_a;

  // Position arithmetic.
  logic [POS_W-1:0] prod_w;
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] pos_sat;
  logic [POS_W-1:0] hp_a;
  logic [POS_W-1:0] hp;

  assign prod_w  = qcnt_q * step_q;
  assign pos_sum = {1'b0, prod_q} + (POS_W + 1)'(offset_q);
  assign pos_sat = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
  assign hp_a    = (POS_W'(offset_q) > phigh_q) ? POS_W'(offset_q) : phigh_q;
  assign hp      = (pos_q > hp_a) ? pos_q : hp_a;

  // Running extremes of the matched reference.
  logic signed [REF_W-1:0] low_new;
  logic signed [REF_W-1:0] high_new;

  assign low_new  = (mref_q < low_q) ? mref_q : low_q;
  assign high_new = (mref_q > high_q) ? mref_q : high_q;

  assign scan_issue = j_q < end_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_issue && !rv_q && !dist_stat.busy) begin
          state_d = ST_REF_ADDR;
        end
      end
      ST_REF_ADDR: begin
        state_d = ST_REF_DATA;
      end
      ST_REF_DATA: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready          = 1'b0;
    trk_re                 = 1'b0;
    ref_re                 = 1'b0;
    fin_fire               = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_SCAN: begin
        trk_re = scan_issue;
      end
      ST_REF_ADDR: begin
        ref_re = 1'b1;
      end
      ST_REF_DATA: begin
      end
      ST_FINISH: begin
        fin_fire = !m_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign load_fire  = in_fire && (in_op == OP_LOAD);
  assign query_fire = in_fire && (in_op == OP_QUERY);

  assign dist_ctrl.clear        = query_fire;
  assign dist_ctrl.sample_valid = rv_q;

  // Next values of the control state.
  always_comb begin
    offset_d  = offset_q;
    step_d    = step_q;
    count_d   = count_q;
    min_idx_d = min_idx_q;
    min_val_d = min_val_q;
    ss_d      = ss_q;
    qcnt_d    = qcnt_q;
    low_d     = low_q;
    high_d    = high_q;
    phigh_d   = phigh_q;
    m_valid_d = m_valid_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POSITION_OFFSET: offset_d = cfg_wdata_i;
        CFG_POSITION_STEP:   step_d   = cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end

    if (load_fire) begin
      count_d   = base_cnt;
      min_idx_d = base_min_idx;
      min_val_d = base_min_val;
      if (in_fs) begin
        ss_d    = '0;
        qcnt_d  = '0;
        low_d   = REF_MAX;
        high_d  = REF_MIN;
        phigh_d = '0;
      end
      if (has_room) begin
        count_d = base_cnt + 1'b1;
        if (in_trk < base_min_val) begin
          min_val_d = in_trk;
          min_idx_d = base_cnt[IW-1:0];
        end
      end
    end

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (fin_fire) begin
      m_valid_d = 1'b1;
      if (dist_stat.found) begin
        ss_d = target;
      end
      if (qcnt_q != QCNT_MAX) begin
        qcnt_d = qcnt_q + 1'b1;
      end
      phigh_d = hp;
      low_d   = low_new;
      high_d  = high_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      offset_q  <= '0;
      step_q    <= STEP_W'(1);
      count_q   <= '0;
      min_idx_q <= '0;
      min_val_q <= TRK_MAX;
      ss_q      <= '0;
      qcnt_q    <= '0;
      low_q     <= REF_MAX;
      high_q    <= REF_MIN;
      phigh_q   <= '0;
      rv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      offset_q  <= offset_d;
      step_q    <= step_d;
      count_q   <= count_d;
      min_idx_q <= min_idx_d;
      min_val_q <= min_val_d;
      ss_q      <= ss_d;
      qcnt_q    <= qcnt_d;
      low_q     <= low_d;
      high_q    <= high_d;
      phigh_q   <= phigh_d;
      rv_q      <= trk_re;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers of the query and of the result.
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      thr_q  <= in_thr;
      end_q  <= CW'(end_b);
      j_q    <= CW'(ss_q);
      prod_q <= prod_w;
    end else if (trk_re) begin
      j_q <= j_q + 1'b1;
    end
    if (trk_re) begin
      ridx_q <= j_q[IW-1:0];
    end
    if (state_q == ST_REF_DATA) begin
      // With no sample stored, the matched reference reads as zero.
      mref_q <= (count_q != '0) ? ref_rdata : '0;
      pos_q  <= pos_sat;
    end
    if (fin_fire) begin
      m_data_q <= {4'h0, hp, high_new, low_new, IDX_OUT_W'(target), mref_q, pos_q};
      m_user_q <= !dist_stat.found;
    end
  end

  // Sample stores.
  ntts_ram #(
    .WIDTH (TRK_W),
    .DEPTH (MAX_SAMPLES)
  ) u_trk_ram (
    .clk_i   (clk_i),
    .we_i    (load_store),
    .waddr_i (base_cnt[IW-1:0]),
    .wdata_i (in_trk),
    .re_i    (trk_re),
    .raddr_i (j_q[IW-1:0]),
    .rdata_o (trk_rdata)
  );

  ntts_ram #(
    .WIDTH (REF_W),
    .DEPTH (MAX_SAMPLES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (load_store),
    .waddr_i (base_cnt[IW-1:0]),
    .wdata_i (in_ref),
    .re_i    (ref_re),
    .raddr_i (target),
    .rdata_o (ref_rdata)
  );

  // Distance unit: one tracking sample per cycle, two stages deep.
  ntts_dist_unit #(
    .IDX_W (IW)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dist_ctrl),
    .threshold_i (thr_q),
    .sample_i    (trk_rdata),
    .idx_i       (ridx_q),
    .stat_o      (dist_stat),
    .target_o    (target)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench of the nearest threshold tracking search unit.
`timescale 1ns / 100ps

module tb;
  import ntts_pkg::*;

  // Store depth and search window used for the instance under test.
  localparam int SAMPLE_DEPTH = 4096;
  localparam int SCAN_WINDOW  = 1000;

  // One expected result item, field by field.
  typedef struct {
    logic [POS_W-1:0]        position;
    logic signed [REF_W-1:0] matched_reference;
    logic [IDX_OUT_W-1:0]    matched_index;
    logic                    empty_window;
    logic signed [REF_W-1:0] lowest_reference;
    logic signed [REF_W-1:0] highest_reference;
    logic [POS_W-1:0]        highest_position;
  } match_t;

  // Keeps its own copy of the frame and search state, works out the result of every
  // accepted query and compares the results taken from the unit in order.
  class match_scoreboard;
    int unsigned             offset_reg;
    int unsigned             step_reg;
    logic signed [REF_W-1:0] ref_mem [SAMPLE_DEPTH];
    logic signed [TRK_W-1:0] trk_mem [SAMPLE_DEPTH];
    int unsigned             sample_count;
    int unsigned             min_index;
    logic signed [TRK_W-1:0] min_value;
    int unsigned             scan_start;
    int unsigned             query_count;
    logic signed [REF_W-1:0] ref_low;
    logic signed [REF_W-1:0] ref_high;
    longint unsigned         pos_high;
    match_t                  expected_matches[$];
    int                      mismatches;

    function new();
      offset_reg = 0;
      step_reg   = 1;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      sample_count = 0;
      min_index    = 0;
      min_value    = TRK_MAX;
      scan_start   = 0;
      query_count  = 0;
      ref_low      = REF_MAX;
      ref_high     = REF_MIN;
      pos_high     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      case (index)
        CFG_POSITION_OFFSET: offset_reg = value[OFFSET_W-1:0];
        CFG_POSITION_STEP:   step_reg = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function match_t run_query(logic signed [THR_W-1:0] thr_v);
      match_t      m;
      int unsigned stop;
      int unsigned hit;
      bit          found;
      longint      gap;
      longint      best;
      longint      pos;
      stop = scan_start + SCAN_WINDOW;
      if (min_index < stop) stop = min_index;
      if (sample_count < stop) stop = sample_count;
      found = 1'b0;
      hit   = 0;
      best  = 0;
      // The first sample at the smallest distance wins, so only a strictly closer one
      // replaces it.
      for (int unsigned j = scan_start; j < stop && j < SAMPLE_DEPTH; j++) begin
        gap = longint'(thr_v) - longint'(trk_mem[j]) * 256;
        if (gap < 0) gap = -gap;
        if (!found || gap < best) begin
          found = 1'b1;
          best  = gap;
          hit   = j;
        end
      end
      if (found) scan_start = hit;
      m.matched_reference = (sample_count > 0) ? ref_mem[hit] : '0;
      pos = longint'(offset_reg) + longint'(query_count) * longint'(step_reg);
      if (pos > longint'(POS_MAX)) pos = longint'(POS_MAX);
      if (query_count < QCNT_MAX) query_count++;
      if (offset_reg > pos_high) pos_high = offset_reg;
      if (pos > pos_high) pos_high = pos;
      if (m.matched_reference < ref_low) ref_low = m.matched_reference;
      if (m.matched_reference > ref_high) ref_high = m.matched_reference;
      m.position          = pos[POS_W-1:0];
      m.matched_index     = hit[IDX_OUT_W-1:0];
      m.empty_window      = !found;
      m.lowest_reference  = ref_low;
      m.highest_reference = ref_high;
      m.highest_position  = pos_high[POS_W-1:0];
      return m;
    endfunction

    // Notes an accepted input item: a load updates the frame, a query adds an expectation.
    function void note_item(op_e op, logic frame_start, logic signed [REF_W-1:0] ref_v,
                            logic signed [TRK_W-1:0] trk_v, logic signed [THR_W-1:0] thr_v);
      if (op == OP_LOAD) begin
        if (frame_start) clear_frame();
        if (sample_count < SAMPLE_DEPTH) begin
          ref_mem[sample_count] = ref_v;
          trk_mem[sample_count] = trk_v;
          if (trk_v < min_value) begin
            min_value = trk_v;
            min_index = sample_count;
          end
          sample_count++;
        end
      end else begin
        expected_matches.insert(expected_matches.size(), run_query(thr_v));
      end
    endfunction

    task report(string what);
      mismatches++;
      // Keep the log short should the unit go wrong on every one of a long run of results.
      if (mismatches <= 30) $display("mismatch: %s", what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Checks one accepted result item against the oldest expectation. Signed fields are
    // passed in braces so that they are zero extended like the slices they are compared to.
    task check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      match_t e;
      if (expected_matches.size() == 0) begin
        report($sformatf("result %h with no query outstanding", tdata));
        return;
      end
      e = expected_matches.pop_front();
      compare_field("position", tdata[27:0], e.position);
      compare_field("matched_reference", tdata[51:28], {e.matched_reference});
      compare_field("matched_index", tdata[63:52], e.matched_index);
      compare_field("lowest_reference", tdata[87:64], {e.lowest_reference});
      compare_field("highest_reference", tdata[111:88], {e.highest_reference});
      compare_field("highest_position", tdata[139:112], e.highest_position);
      compare_field("zero fill", tdata[143:140], '0);
      compare_field("empty_window", tuser[0], e.empty_window);
    endtask
  endclass

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // All inputs of the unit hold known values from the very start.
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [M_TUSER_W-1:0]   m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;

  // Percentage of cycles in which the sender and the receiver idle.
  int tx_idle_pct = 8;
  int rx_idle_pct = 70;
  int sent_items  = 0;

  match_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  nearest_threshold_tracking_search_unit #(
    .MAX_SAMPLES   (SAMPLE_DEPTH),
    .SEARCH_WINDOW (SCAN_WINDOW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // The receiver stalls at random, changing its ready only at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Both handshakes are observed at the rising edge, where every input has been stable
  // since the falling edge and the unit's outputs still hold their values from before it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(op_e'(s_axis_tuser[0]), s_axis_tuser[1], s_axis_tdata[23:0],
                     s_axis_tdata[39:24], s_axis_tdata[63:40]);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Offers one item, after a random number of idle cycles, and holds it until it is
  // taken. Valid is only ever lowered or raised once at any one falling edge.
  task automatic send_item(op_e op, logic frame_start, logic signed [REF_W-1:0] ref_v,
                           logic signed [TRK_W-1:0] trk_v, logic signed [THR_W-1:0] thr_v);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {thr_v, trk_v, ref_v};
    s_axis_tuser  <= {frame_start, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  // A register write takes effect at the rising edge, so the predictor follows it there.
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_register(index, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stops offering items, waits for every outstanding result and then a few more cycles,
  // since a trailing load causes no result and may still be in the unit.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Next tracking sample of a random frame: fully random, falling (so that the minimum
  // lies late and the search windows are long), or within a narrow band full of ties.
  function automatic logic signed [TRK_W-1:0] next_tracking(int mode, inout int level);
    case (mode)
      0: level = int'($urandom_range(0, 65535)) - 32768;
      1: begin
        level = level - int'($urandom_range(0, 300));
        if (level < -32768) level = -32768;
      end
      default: level = int'($urandom_range(0, 16)) - 8;
    endcase
    return TRK_W'(level);
  endfunction

  // Short directed sequence with the reset register values: a query with nothing stored,
  // ties for the minimum and for the distance, extreme fields, a frame start on a query
  // and empty search windows.
  task automatic directed_items();
    send_item(OP_QUERY, 1'b0, REF_MAX, TRK_MAX, '0);
    send_item(OP_LOAD, 1'b1, REF_MIN, TRK_MAX, REF_MAX);
    send_item(OP_LOAD, 1'b0, REF_MAX, 16'sd100, REF_MIN);
    send_item(OP_LOAD, 1'b0, 24'sd5, 16'sd100, '0);
    send_item(OP_LOAD, 1'b0, -24'sd7, 16'sh8000, '0);
    send_item(OP_LOAD, 1'b0, 24'sd9, 16'sh8000, '0);
    send_item(OP_QUERY, 1'b0, '0, '0, 24'sd25600);
    send_item(OP_QUERY, 1'b0, '0, '0, REF_MAX);
    send_item(OP_QUERY, 1'b1, '0, '0, REF_MIN);
    send_item(OP_QUERY, 1'b0, '0, '0, 24'sh000080);
    // The minimum at the first index leaves nothing to search.
    send_item(OP_LOAD, 1'b1, 24'sd3, 16'sh8000, '0);
    send_item(OP_QUERY, 1'b0, '0, '0, '0);
    send_item(OP_LOAD, 1'b0, 24'sd4, 16'sd0, '0);
    send_item(OP_QUERY, 1'b0, '0, '0, REF_MAX);
    // A threshold half way between two samples picks the earlier one.
    send_item(OP_LOAD, 1'b1, 24'sd1, 16'sd10, '0);
    send_item(OP_LOAD, 1'b0, 24'sd2, 16'sd12, '0);
    send_item(OP_LOAD, 1'b0, 24'sd3, -16'sd5, '0);
    send_item(OP_QUERY, 1'b0, '0, '0, 24'sd2816);
    send_item(OP_QUERY, 1'b0, '0, '0, 24'sd3072);
  endtask

  // One frame: mostly a frame start, a run of loads and then queries with a few more loads
  // among them; now and then the frame start is missing or set on a query.
  task automatic random_frame();
    int                      n_loads;
    int                      n_queries;
    int                      mode;
    int                      level;
    logic signed [THR_W-1:0] thr;
    n_loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 24);
    n_queries = $urandom_range(1, 12);
    mode      = $urandom_range(0, 2);
    level     = $urandom_range(0, 32767);
    for (int i = 0; i < n_loads; i++) begin
      send_item(OP_LOAD, i == 0 && $urandom_range(0, 19) != 0, REF_W'($urandom),
                next_tracking(mode, level), THR_W'($urandom));
    end
    for (int q = 0; q < n_queries; q++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(OP_LOAD, 1'b0, REF_W'($urandom), next_tracking(mode, level),
                  THR_W'($urandom));
      end
      case ($urandom_range(0, 3))
        0: thr = THR_W'($urandom);
        1: thr = THR_W'(level * 256 + int'($urandom_range(0, 255)) - 128);
        2: thr = THR_W'((int'($urandom_range(0, 64)) - 32) * 256);
        default: thr = $urandom_range(0, 1) ? REF_MAX : REF_MIN;
      endcase
      send_item(OP_QUERY, $urandom_range(0, 19) == 0, REF_W'($urandom), TRK_W'($urandom), thr);
    end
  endtask

  task automatic random_items(int count);
    int goal;
    goal = sent_items + count;
    while (sent_items < goal) random_frame();
  endtask

  // Stimulus: directed items with the reset register values, then random frames in three
  // idling phases under different register settings, the last one at the largest offset
  // and step.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_items();
    drain();

    write_register(CFG_POSITION_OFFSET, CFG_W'($urandom));
    write_register(CFG_POSITION_STEP, CFG_W'($urandom_range(0, 4095)));
    random_items(200);
    drain();

    tx_idle_pct = 70;
    rx_idle_pct = 8;
    write_register(CFG_POSITION_OFFSET, '0);
    write_register(CFG_POSITION_STEP, '0);
    random_items(200);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_register(CFG_POSITION_OFFSET, CFG_W'(16'hFFFF));
    write_register(CFG_POSITION_STEP, CFG_W'(4095));
    random_items(200);
    drain();

    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog: ends the run as failed should it hang.
  initial begin
    #10000000;
    $display("tb failed");
    $finish;
  end

endmodule
